>>> hw/rtl/swpc_pkg.sv
// ----------------------------------------------------------------------------
// swpc_pkg
// Shared types, constants and arithmetic helpers of the stereo width,
// pan and correlation block.
// ----------------------------------------------------------------------------
`default_nettype none

package swpc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int CFG_W       = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int MODE_MONO_BIT   = 0;
    localparam int MODE_BYPASS_BIT = 1;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    typedef enum logic [2:0] {
        REG_WIDTH, REG_PAN, REG_BAL, REG_MODE, REG_LPG, REG_HPG, REG_A1, REG_A2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TOP_IDLE, TOP_LANES, TOP_MIX, TOP_CORR, TOP_DONE
    } top_state_t;

    typedef enum logic [2:0] {PH_BX, PH_Y, PH_A1, PH_A2, PH_S1} bq_phase_t;
    typedef enum logic [1:0] {BQ_LP1, BQ_LP2, BQ_HP1, BQ_HP2} bq_sel_t;

    typedef enum logic [2:0] {
        MX_SEL, MX_WID, MX_MS, MX_BALM, MX_BALS, MX_PANL, MX_PANR, MX_OUT
    } mix_step_t;

    typedef enum logic [3:0] {
        CR_IDLE, CR_XY, CR_LL, CR_RR, CR_INIT, CR_SQRT, CR_MUL, CR_CHK, CR_DIV, CR_FIN
    } corr_state_t;

    typedef struct packed {
        logic [23:0]        lp_gain;
        logic [23:0]        hp_gain;
        logic signed [24:0] a1;
        logic signed [24:0] a2;
    } coef_t;

    typedef struct packed {
        logic [15:0]        width;
        logic signed [15:0] pan;
        logic signed [15:0] bal;
        logic               mono;
    } mix_cfg_t;

    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        if (v > lim)
            return lim[SAMPLE_BITS-1:0];
        else if (v < -lim - 64'sd1)
            return SAMPLE_BITS'(-lim - 64'sd1);
        return v[SAMPLE_BITS-1:0];
    endfunction

    // quarter-sine entry in Q1.15 from a Q30 angle (Taylor series)
    function automatic logic [15:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2, t, s, e;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        e  = (s + 64'd16384) >> 15;
        return (e > 64'd32768) ? 16'd32768 : e[15:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/swpc_lane.sv
// ----------------------------------------------------------------------------
// swpc_lane
// One channel of the crossover: LP1, LP2, HP1, HP2 biquads (TDF-II) run in
// turn on one shared multiplier, each biquad stepping through phases BX, Y, A1, A2 and S1.
// ----------------------------------------------------------------------------
`default_nettype none

module swpc_lane import swpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] x_in,
    input  coef_t              coef,
    output logic               done,
    output logic signed [31:0] low_out,
    output logic signed [31:0] high_out
);

    bq_sel_t            bq_reg, bq_next;
    bq_phase_t          ph_reg, ph_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [31:0] x_reg, x_next, xin_reg, xin_next, y_reg, y_next;
    logic signed [31:0] low_reg, low_next, high_reg, high_next;
    logic signed [56:0] mbx_reg, mbx_next, pa_reg, pa_next;
    logic signed [31:0] s0_reg [4];
    logic signed [31:0] s1_reg [4];
    logic signed [31:0] s0_new, s1_new;
    logic               wr0, wr1;
    logic [23:0]        g_sel;
    logic signed [63:0] bx2;

    always_comb begin
        g_sel = bq_reg[1] ? coef.hp_gain : coef.lp_gain;
        bx2   = 64'(mbx_reg) <<< 1;
        if (bq_reg[1]) begin
            bx2 = -bx2;
        end
        s0_new = sat32(rshr(bx2 - 64'(pa_reg), 22) + 64'(s1_reg[bq_reg]));
        s1_new = sat32(rshr(64'(mbx_reg) - 64'(pa_reg), 22));

        bq_next   = bq_reg;
        ph_next   = ph_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        xin_next  = xin_reg;
        y_next    = y_reg;
        low_next  = low_reg;
        high_next = high_reg;
        mbx_next  = mbx_reg;
        pa_next   = pa_reg;
        wr0       = 1'b0;
        wr1       = 1'b0;

        if (start) begin
            x_next    = x_in;
            xin_next  = x_in;
            bq_next   = BQ_LP1;
            ph_next   = PH_BX;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            case (ph_reg)
                PH_BX: begin
                    mbx_next = $signed({1'b0, g_sel}) * x_reg;
                    ph_next  = PH_Y;
                end
                PH_Y: begin
                    y_next  = sat32(rshr(64'(mbx_reg), 22) + 64'(s0_reg[bq_reg]));
                    ph_next = PH_A1;
                end
                PH_A1: begin
                    pa_next = coef.a1 * y_reg;
                    ph_next = PH_A2;
                end
                PH_A2: begin
                    wr0     = 1'b1;
                    pa_next = coef.a2 * y_reg;
                    ph_next = PH_S1;
                end
                PH_S1: begin
                    wr1     = 1'b1;
                    ph_next = PH_BX;
                    case (bq_reg)
                        BQ_LP1: begin
                            x_next  = y_reg;
                            bq_next = BQ_LP2;
                        end
                        BQ_LP2: begin
                            low_next = y_reg;
                            x_next   = xin_reg;
                            bq_next  = BQ_HP1;
                        end
                        BQ_HP1: begin
                            x_next  = y_reg;
                            bq_next = BQ_HP2;
                        end
                        BQ_HP2: begin
                            high_next = y_reg;
                            busy_next = 1'b0;
                            done_next = 1'b1;
                        end
                        default: begin
                            busy_next = 1'b0;
                        end
                    endcase
                end
                default: begin
                    ph_next = PH_BX;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bq_reg   <= BQ_LP1;
            ph_reg   <= PH_BX;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                s0_reg[i] <= '0;
                s1_reg[i] <= '0;
            end
        end else begin
            bq_reg   <= bq_next;
            ph_reg   <= ph_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (wr0) begin
                s0_reg[bq_reg] <= s0_new;
            end
            if (wr1) begin
                s1_reg[bq_reg] <= s1_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        xin_reg  <= xin_next;
        y_reg    <= y_next;
        low_reg  <= low_next;
        high_reg <= high_next;
        mbx_reg  <= mbx_next;
        pa_reg   <= pa_next;
    end

    assign done     = done_reg;
    assign low_out  = low_reg;
    assign high_out = high_reg;

endmodule

`default_nettype wire

>>> hw/rtl/swpc_mix.sv
// ----------------------------------------------------------------------------
// swpc_mix
// Merging stage: mono-bass sum, mid/side width, balance and constant-power
// pan, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swpc_mix import swpc_pkg::*; #(
    parameter int PAN_TABLE_SIZE = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  mix_cfg_t                      cfg,
    input  logic signed [31:0]            l_in,
    input  logic signed [31:0]            r_in,
    input  logic signed [31:0]            low_l,
    input  logic signed [31:0]            high_l,
    input  logic signed [31:0]            low_r,
    input  logic signed [31:0]            high_r,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] nl_out,
    output logic signed [SAMPLE_BITS-1:0] nr_out
);

    localparam int IW = $clog2(PAN_TABLE_SIZE + 1);

    logic [15:0] rom [PAN_TABLE_SIZE+1];

    for (genvar k = 0; k <= PAN_TABLE_SIZE; k++) begin : g_rom
        localparam logic [63:0] ANG = (64'(k) * HALF_PI_Q30) / PAN_TABLE_SIZE;
        assign rom[k] = sine_q15(ANG);
    end

    mix_step_t          st_reg, st_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic signed [31:0] l_reg, l_next, r_reg, r_next;
    logic signed [32:0] sum_reg, sum_next, sumlr;
    logic signed [49:0] dw_reg, dw_next;
    logic signed [48:0] bp_reg, bp_next;
    logic signed [48:0] pal_reg, pal_next, par_reg, par_next;
    logic signed [49:0] sal_reg, sal_next, sar_reg, sar_next;
    logic [15:0]        pl_reg, pl_next, pr_reg, pr_next;
    logic signed [SAMPLE_BITS-1:0] nl_reg, nl_next, nr_reg, nr_next;
    logic signed [15:0] bal_c, pan_c;
    logic signed [16:0] bal_f;
    logic [16:0]        t_u;
    logic [31:0]        idx_full;
    logic [IW-1:0]      idx;
    logic signed [63:0] mono;

    always_comb begin
        bal_c = (cfg.bal < -16'sd16384) ? -16'sd16384 :
                (cfg.bal > 16'sd16384) ? 16'sd16384 : cfg.bal;
        pan_c = (cfg.pan < -16'sd16384) ? -16'sd16384 :
                (cfg.pan > 16'sd16384) ? 16'sd16384 : cfg.pan;
        bal_f = (bal_c < 16'sd0) ? 17'sd16384 + 17'(bal_c) : 17'sd16384 - 17'(bal_c);
        t_u      = 17'(17'(pan_c) + 17'sd16384);
        idx_full = ((32'(t_u) * 32'(PAN_TABLE_SIZE)) + 32'd16384) >> 15;
        idx      = (idx_full > 32'(PAN_TABLE_SIZE)) ? IW'(PAN_TABLE_SIZE) : idx_full[IW-1:0];
        mono     = (64'(low_l) + 64'(low_r)) >>> 1;
        sumlr    = 33'(l_reg) + 33'(r_reg);

        st_next   = st_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        l_next    = l_reg;
        r_next    = r_reg;
        sum_next  = sum_reg;
        dw_next   = dw_reg;
        bp_next   = bp_reg;
        pal_next  = pal_reg;
        par_next  = par_reg;
        sal_next  = sal_reg;
        sar_next  = sar_reg;
        pl_next   = pl_reg;
        pr_next   = pr_reg;
        nl_next   = nl_reg;
        nr_next   = nr_reg;

        if (start) begin
            busy_next = 1'b1;
            st_next   = MX_SEL;
        end else if (busy_reg) begin
            case (st_reg)
                MX_SEL: begin
                    if (cfg.mono) begin
                        l_next = sat32(mono + 64'(high_l));
                        r_next = sat32(mono + 64'(high_r));
                    end else begin
                        l_next = l_in;
                        r_next = r_in;
                    end
                    pr_next = rom[idx];
                    pl_next = rom[IW'(PAN_TABLE_SIZE) - idx];
                    st_next = MX_WID;
                end
                MX_WID: begin
                    sum_next = sumlr;
                    dw_next  = (33'(l_reg) - 33'(r_reg)) * $signed({1'b0, cfg.width});
                    st_next  = MX_MS;
                end
                MX_MS: begin
                    l_next  = sat32(rshr((64'(sum_reg) <<< 14) + 64'(dw_reg), 15));
                    r_next  = sat32(rshr((64'(sum_reg) <<< 14) - 64'(dw_reg), 15));
                    st_next = MX_BALM;
                end
                MX_BALM: begin
                    bp_next = ((bal_c < 16'sd0) ? r_reg : l_reg) * bal_f;
                    st_next = MX_BALS;
                end
                MX_BALS: begin
                    if (bal_c < 16'sd0) begin
                        r_next = sat32(rshr(64'(bp_reg), 14));
                    end else if (bal_c > 16'sd0) begin
                        l_next = sat32(rshr(64'(bp_reg), 14));
                    end
                    st_next = MX_PANL;
                end
                MX_PANL: begin
                    pal_next = l_reg * $signed({1'b0, pl_reg});
                    sal_next = sumlr * (17'sd32768 - $signed({1'b0, pl_reg}));
                    st_next  = MX_PANR;
                end
                MX_PANR: begin
                    par_next = r_reg * $signed({1'b0, pr_reg});
                    sar_next = sumlr * (17'sd32768 - $signed({1'b0, pr_reg}));
                    st_next  = MX_OUT;
                end
                MX_OUT: begin
                    nl_next   = sat_smp(rshr((64'(pal_reg) <<< 1) + 64'(sal_reg), 16));
                    nr_next   = sat_smp(rshr((64'(par_reg) <<< 1) + 64'(sar_reg), 16));
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= MX_SEL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        sum_reg <= sum_next;
        dw_reg  <= dw_next;
        bp_reg  <= bp_next;
        pal_reg <= pal_next;
        par_reg <= par_next;
        sal_reg <= sal_next;
        sar_reg <= sar_next;
        pl_reg  <= pl_next;
        pr_reg  <= pr_next;
        nl_reg  <= nl_next;
        nr_reg  <= nr_next;
    end

    assign done   = done_reg;
    assign nl_out = nl_reg;
    assign nr_out = nr_reg;

endmodule

`default_nettype wire

>>> hw/rtl/swpc_corr.sv
// ----------------------------------------------------------------------------
// swpc_corr
// Windowed correlation: saturating product sums, two parallel bit-pair
// square roots, one product and a 16-step restoring divide at window close.
// ----------------------------------------------------------------------------
`default_nettype none

module swpc_corr import swpc_pkg::*; #(
    parameter int WINDOW_LENGTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] nl_in,
    input  logic signed [SAMPLE_BITS-1:0] nr_in,
    output logic                          done,
    output logic                          win_ready,
    output logic signed [15:0]            held
);

    localparam int CW = $clog2(WINDOW_LENGTH + 1);
    localparam logic signed [58:0] CROSS_MAX = 59'sd144115188075855871;
    localparam logic signed [58:0] CROSS_MIN = -59'sd144115188075855872;
    localparam logic [57:0] CORR_FLOOR = 58'((64'd1 << (2 * (SAMPLE_BITS - 1))) / 10000);

    corr_state_t        st_reg, st_next;
    logic signed [57:0] cross_reg, cross_next;
    logic [57:0]        le_reg, le_next, re_reg, re_next;
    logic [CW-1:0]      cnt_reg, cnt_next, cnt_inc;
    logic signed [15:0] held_reg, held_next;
    logic               done_reg, done_next, rdy_reg, rdy_next;
    logic signed [SAMPLE_BITS-1:0] a_reg, a_next, b_reg, b_next;
    logic signed [47:0] prod_reg, prod_next;
    logic [57:0]        v_reg [2];
    logic [57:0]        v_next [2];
    logic [57:0]        rt_reg [2];
    logic [57:0]        rt_next [2];
    logic [4:0]         i_reg, i_next;
    logic [57:0]        d_reg, d_next, mag;
    logic [58:0]        rem_reg, rem_next, rem2;
    logic [16:0]        q_reg, q_next, qn;
    logic               neg_reg, neg_next;
    logic signed [58:0] xs;
    logic [58:0]        es;
    logic [57:0]        bitv, trial [2];

    always_comb begin
        cnt_inc = cnt_reg + 1'b1;
        xs      = 59'(cross_reg) + 59'(prod_reg);
        bitv    = 58'd1 << {i_reg, 1'b0};
        mag     = cross_reg[57] ? 58'(-cross_reg) : 58'(cross_reg);
        rem2    = {rem_reg[57:0], 1'b0};
        es      = '0;

        st_next    = st_reg;
        cross_next = cross_reg;
        le_next    = le_reg;
        re_next    = re_reg;
        cnt_next   = cnt_reg;
        held_next  = held_reg;
        done_next  = 1'b0;
        rdy_next   = 1'b0;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        i_next     = i_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        qn         = q_reg;
        neg_next   = neg_reg;
        for (int j = 0; j < 2; j++) begin
            v_next[j]  = v_reg[j];
            rt_next[j] = rt_reg[j];
            trial[j]   = rt_reg[j] + bitv;
        end

        case (st_reg)
            CR_IDLE: begin
                if (start) begin
                    a_next    = nl_in;
                    b_next    = nr_in;
                    prod_next = nl_in * nr_in;
                    st_next   = CR_XY;
                end
            end
            CR_XY: begin
                if (xs > CROSS_MAX) begin
                    cross_next = CROSS_MAX[57:0];
                end else if (xs < CROSS_MIN) begin
                    cross_next = CROSS_MIN[57:0];
                end else begin
                    cross_next = xs[57:0];
                end
                prod_next = a_reg * a_reg;
                st_next   = CR_LL;
            end
            CR_LL: begin
                es        = 59'(le_reg) + 59'(prod_reg[46:0]);
                le_next   = es[58] ? '1 : es[57:0];
                prod_next = b_reg * b_reg;
                st_next   = CR_RR;
            end
            CR_RR: begin
                es       = 59'(re_reg) + 59'(prod_reg[46:0]);
                re_next  = es[58] ? '1 : es[57:0];
                cnt_next = cnt_inc;
                if (cnt_inc >= CW'(WINDOW_LENGTH)) begin
                    st_next = CR_INIT;
                end else begin
                    done_next = 1'b1;
                    st_next   = CR_IDLE;
                end
            end
            CR_INIT: begin
                v_next[0]  = le_reg;
                v_next[1]  = re_reg;
                rt_next[0] = '0;
                rt_next[1] = '0;
                i_next     = 5'd28;
                st_next    = CR_SQRT;
            end
            CR_SQRT: begin
                for (int j = 0; j < 2; j++) begin
                    if (v_reg[j] >= trial[j]) begin
                        v_next[j]  = v_reg[j] - trial[j];
                        rt_next[j] = (rt_reg[j] >> 1) + bitv;
                    end else begin
                        rt_next[j] = rt_reg[j] >> 1;
                    end
                end
                i_next = i_reg - 5'd1;
                if (i_reg == 5'd0) begin
                    st_next = CR_MUL;
                end
            end
            CR_MUL: begin
                d_next  = rt_reg[0][28:0] * rt_reg[1][28:0];
                st_next = CR_CHK;
            end
            CR_CHK: begin
                neg_next = cross_reg[57];
                if (!(d_reg > CORR_FLOOR)) begin
                    neg_next = 1'b0;
                    q_next   = 17'd32767;
                    st_next  = CR_FIN;
                end else if (mag >= d_reg) begin
                    q_next  = 17'd32768;
                    st_next = CR_FIN;
                end else begin
                    rem_next = 59'(mag);
                    q_next   = '0;
                    i_next   = 5'd15;
                    st_next  = CR_DIV;
                end
            end
            CR_DIV: begin
                if (rem2 >= 59'(d_reg)) begin
                    rem_next = rem2 - 59'(d_reg);
                    qn       = {q_reg[15:0], 1'b1};
                end else begin
                    rem_next = rem2;
                    qn       = {q_reg[15:0], 1'b0};
                end
                i_next = i_reg - 5'd1;
                if (i_reg == 5'd0) begin
                    q_next  = (qn + 17'd1) >> 1;
                    st_next = CR_FIN;
                end else begin
                    q_next = qn;
                end
            end
            CR_FIN: begin
                if (neg_reg) begin
                    held_next = 16'(-q_reg);
                end else begin
                    held_next = (q_reg > 17'd32767) ? 16'sd32767 : q_reg[15:0];
                end
                cross_next = '0;
                le_next    = '0;
                re_next    = '0;
                cnt_next   = '0;
                rdy_next   = 1'b1;
                done_next  = 1'b1;
                st_next    = CR_IDLE;
            end
            default: begin
                st_next = CR_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= CR_IDLE;
            cross_reg <= '0;
            le_reg    <= '0;
            re_reg    <= '0;
            cnt_reg   <= '0;
            held_reg  <= '0;
            done_reg  <= 1'b0;
            rdy_reg   <= 1'b0;
        end else begin
            st_reg    <= st_next;
            cross_reg <= cross_next;
            le_reg    <= le_next;
            re_reg    <= re_next;
            cnt_reg   <= cnt_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
            rdy_reg   <= rdy_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        i_reg    <= i_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        for (int j = 0; j < 2; j++) begin
            v_reg[j]  <= v_next[j];
            rt_reg[j] <= rt_next[j];
        end
    end

    assign done      = done_reg;
    assign win_ready = rdy_reg;
    assign held      = held_reg;

endmodule

`default_nettype wire

>>> hw/rtl/stereo_width_pan_correlator.sv
// ----------------------------------------------------------------------------
// stereo_width_pan_correlator
// Stereo imager: mono-bass crossover, mid/side width, balance, pan and a
// windowed L/R correlation meter. One item in flight at a time.
// Path, accept to m_tvalid: bypass goes straight to the output register; processing runs
// the mixer and correlator, after the two crossover lanes (four biquads each on one
// multiplier) when mono bass is on, plus square roots and divider at a window close.
// Input is taken while a result waits in the output register.
// Reset: synchronous active-low; registers to defaults, filters and sums zero.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_width_pan_correlator import swpc_pkg::*; #(
    parameter int WINDOW_LENGTH  = 1024,
    parameter int PAN_TABLE_SIZE = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // left_in, right_in
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // left_out, right_out, correlation_value
    output logic [0:0]           m_tuser,   // corr_ready
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    top_state_t         state_reg, state_next;
    logic [15:0]        width_reg;
    logic signed [15:0] pan_reg, bal_reg;
    logic [1:0]         mode_reg;
    coef_t              coef_reg;
    mix_cfg_t           mix_cfg;

    logic signed [31:0] l_reg, l_next, r_reg, r_next;
    logic signed [SAMPLE_BITS-1:0] ol_reg, ol_next, or_reg, or_next;
    logic               rdy_reg, rdy_next;
    logic               mv_reg;
    logic [63:0]        md_reg;
    logic               mu_reg;
    logic               s_acc, out_load;
    logic               lane_start, mix_start, corr_start;
    logic               done_l, done_r, mix_done, corr_done, win_ready;
    logic signed [31:0] low_l, high_l, low_r, high_r;
    logic signed [SAMPLE_BITS-1:0] nl, nr;
    logic signed [15:0] held;

    assign s_tready = (state_reg == TOP_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_load = (state_reg == TOP_DONE) && (!mv_reg || m_tready);
    assign mix_cfg  = '{width: width_reg, pan: pan_reg, bal: bal_reg,
                        mono: mode_reg[MODE_MONO_BIT]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= 16'd16384;
            pan_reg   <= '0;
            bal_reg   <= '0;
            mode_reg  <= '0;
            coef_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_WIDTH: width_reg        <= cfg_data[15:0];
                REG_PAN:   pan_reg          <= cfg_data[15:0];
                REG_BAL:   bal_reg          <= cfg_data[15:0];
                REG_MODE:  mode_reg         <= cfg_data[1:0];
                REG_LPG:   coef_reg.lp_gain <= cfg_data[23:0];
                REG_HPG:   coef_reg.hp_gain <= cfg_data[23:0];
                REG_A1:    coef_reg.a1      <= cfg_data;
                REG_A2:    coef_reg.a2      <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        ol_next    = ol_reg;
        or_next    = or_reg;
        rdy_next   = rdy_reg;
        lane_start = 1'b0;
        mix_start  = 1'b0;
        corr_start = 1'b0;
        case (state_reg)
            TOP_IDLE: begin
                if (s_acc) begin
                    l_next  = 32'($signed(s_tdata[23:0]));
                    r_next  = 32'($signed(s_tdata[47:24]));
                    ol_next = s_tdata[23:0];
                    or_next = s_tdata[47:24];
                    if (mode_reg[MODE_BYPASS_BIT]) begin
                        rdy_next   = 1'b0;
                        state_next = TOP_DONE;
                    end else if (mode_reg[MODE_MONO_BIT]) begin
                        lane_start = 1'b1;
                        state_next = TOP_LANES;
                    end else begin
                        mix_start  = 1'b1;
                        state_next = TOP_MIX;
                    end
                end
            end
            TOP_LANES: begin
                if (done_l && done_r) begin
                    mix_start  = 1'b1;
                    state_next = TOP_MIX;
                end
            end
            TOP_MIX: begin
                if (mix_done) begin
                    corr_start = 1'b1;
                    ol_next    = nl;
                    or_next    = nr;
                    state_next = TOP_CORR;
                end
            end
            TOP_CORR: begin
                if (corr_done) begin
                    rdy_next   = win_ready;
                    state_next = TOP_DONE;
                end
            end
            TOP_DONE: begin
                if (out_load) begin
                    state_next = TOP_IDLE;
                end
            end
            default: begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TOP_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        ol_reg  <= ol_next;
        or_reg  <= or_next;
        rdy_reg <= rdy_next;
        if (out_load) begin
            md_reg <= {held, or_reg, ol_reg};
            mu_reg <= rdy_reg;
        end
    end

    swpc_lane u_lane_l (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lane_start),
        .x_in     (l_next),
        .coef     (coef_reg),
        .done     (done_l),
        .low_out  (low_l),
        .high_out (high_l)
    );

    swpc_lane u_lane_r (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lane_start),
        .x_in     (r_next),
        .coef     (coef_reg),
        .done     (done_r),
        .low_out  (low_r),
        .high_out (high_r)
    );

    swpc_mix #(.PAN_TABLE_SIZE(PAN_TABLE_SIZE)) u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .cfg     (mix_cfg),
        .l_in    (l_reg),
        .r_in    (r_reg),
        .low_l   (low_l),
        .high_l  (high_l),
        .low_r   (low_r),
        .high_r  (high_r),
        .done    (mix_done),
        .nl_out  (nl),
        .nr_out  (nr)
    );

    swpc_corr #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (corr_start),
        .nl_in     (nl),
        .nr_in     (nr),
        .done      (corr_done),
        .win_ready (win_ready),
        .held      (held)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    a_lane_done_in_lanes: assert property (@(posedge aclk) disable iff (!aresetn)
        done_l |-> state_reg == TOP_LANES)
        else $error("lane finished outside lane phase");

    a_mix_done_in_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        mix_done |-> state_reg == TOP_MIX)
        else $error("mixer finished outside mix phase");

    a_corr_done_in_corr: assert property (@(posedge aclk) disable iff (!aresetn)
        corr_done |-> state_reg == TOP_CORR)
        else $error("correlator finished outside corr phase");

    a_bypass_direct: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && mode_reg[MODE_BYPASS_BIT] |=> state_reg == TOP_DONE)
        else $error("bypass item did not go straight to output");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_width_pan_correlator. A queue-fed stream
// driver and a monitor with random idling exercise bypass, mid/side width,
// balance, pan, the mono-bass crossover and the correlation window close.
// Expected items come from an in-bench bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import swpc_pkg::*;

    localparam int WIN       = 1024;
    localparam int PAN_N     = 256;
    localparam int CYC_LIMIT = 3000000;
    localparam int HOLD_AT   = 1100;
    localparam int HOLD_LEN  = 600;
    localparam int SETTLE    = 150;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
        logic        ready;
        logic [15:0] corr;
    } pair_out_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;   // left_in, right_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;        // left_out, right_out, correlation_value
    logic [0:0]           m_tuser;        // corr_ready
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    always #5 aclk = ~aclk;

    stereo_width_pan_correlator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow configuration
    logic [15:0] sh_width = 16'd16384, sh_pan = '0, sh_bal = '0;
    logic [1:0]  sh_mode = '0;
    logic [23:0] sh_lpg = '0, sh_hpg = '0;
    logic [24:0] sh_a1 = '0, sh_a2 = '0;

    // predictor state
    longint      flt_dly [16];
    longint      xy_sum, ll_sum, rr_sum, held_corr;
    int          win_cnt;
    longint      sine_tab [PAN_N+1];

    logic [47:0] pending_pairs [$];
    pair_out_t   expected_pairs [$];
    int          err_cnt = 0;
    int          rx_cnt = 0;
    longint      cyc = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint clip32(longint v);
        return clip(v, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic longint rnd_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    task automatic fill_sine_tab();
        longint unsigned x, x2, t, s, e;
        for (int k = 0; k <= PAN_N; k++) begin
            x  = (longint'(k) * HALF_PI_Q30) / PAN_N;
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 110;
            t  = Q30_ONE - ((x2 * t) >> 30) / 72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            e  = (s + 64'd16384) >> 15;
            sine_tab[k] = (e > 64'd32768) ? 32768 : longint'(e);
        end
    endtask

    function automatic longint biquad_step(int k, longint x, longint b0, longint b1,
                                           longint b2);
        longint a1, a2, y;
        a1 = longint'($signed(sh_a1));
        a2 = longint'($signed(sh_a2));
        y = clip32(rnd_shift(b0 * x, 22) + flt_dly[2*k]);
        flt_dly[2*k]   = clip32(rnd_shift(b1 * x - a1 * y, 22) + flt_dly[2*k+1]);
        flt_dly[2*k+1] = clip32(rnd_shift(b2 * x - a2 * y, 22));
        return y;
    endfunction

    function automatic longint window_corr();
        longint unsigned d, mag, rem, q;
        logic neg;
        d = int_sqrt(longint'(ll_sum)) * int_sqrt(longint'(rr_sum));
        if (!(d > (64'd1 << 46) / 64'd10000)) return 32767;
        neg = xy_sum < 0;
        mag = neg ? -xy_sum : xy_sum;
        q = 0;
        if (mag >= d) begin
            q = 32768;
        end else begin
            rem = mag;
            for (int i = 0; i < 16; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= d) begin
                    rem = rem - d;
                    q = q | 1;
                end
            end
            q = (q + 1) >> 1;
        end
        if (neg) return -longint'(q);
        return q > 32767 ? 32767 : longint'(q);
    endfunction

    function automatic pair_out_t process_pair(logic [47:0] din);
        pair_out_t o;
        longint l, r, g, h, lo_l, lo_r, hi_l, hi_r, mono, w, b, p, nl, nr, pl, pr, idx;
        l = longint'($signed(din[23:0]));
        r = longint'($signed(din[47:24]));
        o.ready = 1'b0;
        if (sh_mode[MODE_BYPASS_BIT]) begin
            o.left = din[23:0];
            o.right = din[47:24];
            o.corr = held_corr[15:0];
            return o;
        end
        if (sh_mode[MODE_MONO_BIT]) begin
            g = sh_lpg;
            h = sh_hpg;
            lo_l = biquad_step(0, l, g, 2 * g, g);
            lo_l = biquad_step(1, lo_l, g, 2 * g, g);
            lo_r = biquad_step(2, r, g, 2 * g, g);
            lo_r = biquad_step(3, lo_r, g, 2 * g, g);
            hi_l = biquad_step(4, l, h, -2 * h, h);
            hi_l = biquad_step(5, hi_l, h, -2 * h, h);
            hi_r = biquad_step(6, r, h, -2 * h, h);
            hi_r = biquad_step(7, hi_r, h, -2 * h, h);
            mono = (lo_l + lo_r) >>> 1;
            l = clip32(mono + hi_l);
            r = clip32(mono + hi_r);
        end
        w = sh_width;
        nl = clip32(rnd_shift((l + r) * 16384 + (l - r) * w, 15));
        nr = clip32(rnd_shift((l + r) * 16384 - (l - r) * w, 15));
        l = nl;
        r = nr;
        b = clip(longint'($signed(sh_bal)), -16384, 16384);
        if (b < 0)
            r = clip32(rnd_shift(r * (16384 + b), 14));
        else if (b > 0)
            l = clip32(rnd_shift(l * (16384 - b), 14));
        p = clip(longint'($signed(sh_pan)), -16384, 16384);
        idx = ((p + 16384) * PAN_N + 16384) >>> 15;
        if (idx > PAN_N) idx = PAN_N;
        pr = sine_tab[idx];
        pl = sine_tab[PAN_N - idx];
        nl = clip(rnd_shift(2 * l * pl + (l + r) * (32768 - pl), 16), -8388608, 8388607);
        nr = clip(rnd_shift(2 * r * pr + (l + r) * (32768 - pr), 16), -8388608, 8388607);
        xy_sum = clip(xy_sum + nl * nr, -(64'sd1 <<< 57), (64'sd1 <<< 57) - 1);
        ll_sum = clip(ll_sum + nl * nl, 0, (64'sd1 <<< 58) - 1);
        rr_sum = clip(rr_sum + nr * nr, 0, (64'sd1 <<< 58) - 1);
        win_cnt++;
        if (win_cnt >= WIN) begin
            held_corr = window_corr();
            xy_sum = 0;
            ll_sum = 0;
            rr_sum = 0;
            win_cnt = 0;
            o.ready = 1'b1;
        end
        o.left = nl[23:0];
        o.right = nr[23:0];
        o.corr = held_corr[15:0];
        return o;
    endfunction

    // driver
    int tx_gap = 0;
    int tx_cnt = 0;
    always @(posedge aclk) begin
        logic load;
        cyc <= cyc + 1;
        load = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_pairs.push_back(process_pair(s_tdata));
                tx_cnt <= tx_cnt + 1;
                tx_gap <= (tx_cnt % 128 < 64) ? $urandom_range(0, 17) : 0;
                if (!((tx_cnt % 128 < 64)) && pending_pairs.size() != 0) load = 1'b1;
                else s_tvalid <= 1'b0;
            end else if (!s_tvalid) begin
                if (tx_gap > 0) tx_gap <= tx_gap - 1;
                else if (pending_pairs.size() != 0) load = 1'b1;
            end
            if (load) begin
                s_tdata <= pending_pairs.pop_front();
                s_tvalid <= 1'b1;
            end
        end
    end

    // monitor
    int rx_gap = 0;
    always @(posedge aclk) begin
        pair_out_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                rx_cnt <= rx_cnt + 1;
                if (expected_pairs.size() == 0) begin
                    $error("unexpected item: tdata %h tuser %b", m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    e = expected_pairs.pop_front();
                    if (m_tdata[23:0] !== e.left) begin
                        $error("left_out exp %h got %h", e.left, m_tdata[23:0]);
                        err_cnt++;
                    end
                    if (m_tdata[47:24] !== e.right) begin
                        $error("right_out exp %h got %h", e.right, m_tdata[47:24]);
                        err_cnt++;
                    end
                    if (m_tdata[63:48] !== e.corr) begin
                        $error("correlation_value exp %h got %h", e.corr, m_tdata[63:48]);
                        err_cnt++;
                    end
                    if (m_tuser[0] !== e.ready) begin
                        $error("corr_ready exp %b got %b", e.ready, m_tuser[0]);
                        err_cnt++;
                    end
                end
                if (rx_cnt + 1 == HOLD_AT) begin
                    rx_gap <= HOLD_LEN;
                    m_tready <= 1'b0;
                end else if ((rx_cnt / 96) % 2 == 0) begin
                    rx_gap <= $urandom_range(0, 17);
                    m_tready <= 1'b0;
                end
            end else if (!m_tready) begin
                if (rx_gap > 0) rx_gap <= rx_gap - 1;
                else m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cyc > CYC_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_WIDTH: sh_width = val[15:0];
            REG_PAN:   sh_pan = val[15:0];
            REG_BAL:   sh_bal = val[15:0];
            REG_MODE:  sh_mode = val[1:0];
            REG_LPG:   sh_lpg = val[23:0];
            REG_HPG:   sh_hpg = val[23:0];
            REG_A1:    sh_a1 = val;
            REG_A2:    sh_a2 = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] w, logic [15:0] p, logic [15:0] b, logic [1:0] m,
                           logic [23:0] lg, logic [23:0] hg, logic [24:0] a1,
                           logic [24:0] a2);
        write_reg(REG_WIDTH, w);
        write_reg(REG_PAN, p);
        write_reg(REG_BAL, b);
        write_reg(REG_MODE, m);
        write_reg(REG_LPG, lg);
        write_reg(REG_HPG, hg);
        write_reg(REG_A1, a1);
        write_reg(REG_A2, a2);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_tvalid || expected_pairs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample(int quiet);
        int k;
        k = $urandom_range(0, 9);
        if (quiet) return 24'($signed($urandom_range(0, 600)) - 300);
        if (k < 5) return 24'($urandom);
        if (k < 7) return ($urandom_range(0, 1) ? 24'h7fffff : 24'h800000)
                          ^ 24'($urandom_range(0, 3));
        return 24'($signed($urandom_range(0, 65535)) - 32768);
    endfunction

    task automatic queue_random(int n, int quiet);
        logic [23:0] l, r;
        for (int i = 0; i < n; i++) begin
            l = rand_sample(quiet);
            case ($urandom_range(0, 5))
                0: r = l;
                1: r = -l;
                default: r = rand_sample(quiet);
            endcase
            pending_pairs.push_back({r, l});
        end
        wait_idle();
    endtask

    localparam logic [23:0] LP_B0 = 24'd3960;
    localparam logic [23:0] HP_B0 = 24'd4012000;
    localparam logic [24:0] A1_CO = -25'sd8015000;
    localparam logic [24:0] A2_CO = 25'sd3838000;

    initial begin
        fill_sine_tab();
        foreach (flt_dly[i]) flt_dly[i] = 0;
        xy_sum = 0; ll_sum = 0; rr_sum = 0; held_corr = 0; win_cnt = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        // defaults, then directed extremes under each processing stage
        pending_pairs.push_back({24'h000000, 24'h000000});
        pending_pairs.push_back({24'h7fffff, 24'h7fffff});
        pending_pairs.push_back({24'h800000, 24'h800000});
        pending_pairs.push_back({24'h800000, 24'h7fffff});
        pending_pairs.push_back({24'h7fffff, 24'h800000});
        pending_pairs.push_back({24'hffffff, 24'h000001});
        wait_idle();
        set_all(16'd0, -16'sd16384, 16'sd16384, 2'b00, '0, '0, '0, '0);
        pending_pairs.push_back({24'h800000, 24'h7fffff});
        pending_pairs.push_back({24'h123456, 24'hedcba9});
        pending_pairs.push_back({24'h7fffff, 24'h7fffff});
        wait_idle();
        set_all(16'hffff, 16'h7fff, 16'h8000, 2'b00, '0, '0, '0, '0);
        pending_pairs.push_back({24'h800000, 24'h7fffff});
        pending_pairs.push_back({24'h7fffff, 24'h800000});
        pending_pairs.push_back({24'h400000, 24'hc00000});
        wait_idle();
        set_all(16'd32768, 16'sd16384, -16'sd16384, 2'b01, 24'hffffff, 24'hffffff,
                25'h0ffffff, 25'h1000000);
        pending_pairs.push_back({24'h7fffff, 24'h7fffff});
        pending_pairs.push_back({24'h800000, 24'h800000});
        pending_pairs.push_back({24'h000000, 24'h000000});
        wait_idle();
        set_all(16'd16384, '0, '0, 2'b10, '0, '0, '0, '0);
        pending_pairs.push_back({24'h800000, 24'h7fffff});
        pending_pairs.push_back({24'h000001, 24'hffffff});
        wait_idle();

        // fill up to the first window close
        set_all(16'd16384, '0, '0, 2'b00, '0, '0, '0, '0);
        queue_random(WIN - (win_cnt % WIN), 0);

        set_all(16'd0, -16'sd16384, 16'sd16384, 2'b00, '0, '0, '0, '0);
        queue_random(60, 0);
        set_all(16'd32768, 16'sd16384, -16'sd16384, 2'b00, '0, '0, '0, '0);
        queue_random(60, 0);
        set_all(16'hffff, 16'h8000, 16'h7fff, 2'b00, '0, '0, '0, '0);
        queue_random(50, 1);
        set_all(16'd20000, 16'sd5000, -16'sd3000, 2'b01, LP_B0, HP_B0, A1_CO, A2_CO);
        queue_random(70, 0);
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 2'b01, 24'($urandom),
                24'($urandom), 25'($urandom), 25'($urandom));
        queue_random(50, 0);
        set_all(16'($urandom), 16'($urandom), 16'($urandom), 2'b11, 24'($urandom),
                24'($urandom), 25'($urandom), 25'($urandom));
        queue_random(40, 0);
        for (int ph = 0; ph < 3; ph++) begin
            set_all(16'($urandom), 16'($urandom_range(0, 32768) - 16384),
                    16'($urandom_range(0, 32768) - 16384), 2'($urandom_range(0, 1)),
                    24'($urandom), 24'($urandom), 25'($urandom), 25'($urandom));
            queue_random(20, 0);
        end

        if (err_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
